// File: rtl/i64dm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i64dm_pkg
// Shared types and constants for the 64-bit divide/modulo unit.
// ----------------------------------------------------------------------------
package i64dm_pkg;

  localparam int unsigned W = 64;
  localparam int unsigned STAGES = 64;

  typedef enum logic [1:0] {
    CMD_SDIV = 2'd0,
    CMD_SREM = 2'd1,
    CMD_UDIV = 2'd2,
    CMD_UREM = 2'd3
  } cmd_t;

  // Per-request control that rides along the cell chain.
  typedef struct packed {
    logic          valid;
    logic          want_rem;
    logic          neg_q;
    logic          neg_r;
    logic          zero;
    logic [W-1:0]  orig_a;
  } ctl_t;

  // Partial remainder, quotient/dividend shift register and divisor.
  typedef struct packed {
    logic [W-1:0] rem;
    logic [W-1:0] quo;
    logic [W-1:0] dvs;
  } dat_t;

endpackage

// File: rtl/int64_divide_modulo_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int64_divide_modulo_unit
// Pipeline: input register (loads at the accepting edge), then 64 radix-2
//   cells, then the output register.
// Throughput: one request per cycle; the whole chain advances together and
//   holds while the output register is full and stalled.
// Reset: rst clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module int64_divide_modulo_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            cmd,
  input  logic [63:0]           dividend,
  input  logic [63:0]           divisor,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [63:0]           result,
  output logic                  div_by_zero
);
  import i64dm_pkg::*;

  // Chain advances whenever the output slot is free or being drained.
  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // Front end: signs, magnitudes, flags.
  logic  is_signed, neg_a, neg_b;
  logic [W-1:0] ma, mb;
  ctl_t  ctl0;
  dat_t  dat0;

  always_comb begin
    is_signed = (cmd == CMD_SDIV) || (cmd == CMD_SREM);
    neg_a     = is_signed && dividend[W-1];
    neg_b     = is_signed && divisor[W-1];
    ma        = neg_a ? (~dividend + 1'b1) : dividend;
    mb        = neg_b ? (~divisor + 1'b1) : divisor;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl0.valid <= 1'b0;
    end else if (adv) begin
      ctl0.valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl0.want_rem <= cmd[0];
      ctl0.neg_q    <= neg_a ^ neg_b;
      ctl0.neg_r    <= neg_a;
      ctl0.zero     <= (divisor == '0);
      ctl0.orig_a   <= dividend;
      dat0.rem      <= '0;
      dat0.quo      <= ma;
      dat0.dvs      <= mb;
    end
  end

  // Row of division cells, one quotient bit each.
  ctl_t ctl_c [STAGES+1];
  dat_t dat_c [STAGES+1];
  assign ctl_c[0] = ctl0;
  assign dat_c[0] = dat0;

  for (genvar i = 0; i < STAGES; i++) begin : g_cell
    i64dm_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (adv),
      .ctl_in  (ctl_c[i]),
      .dat_in  (dat_c[i]),
      .ctl_out (ctl_c[i+1]),
      .dat_out (dat_c[i+1])
    );
  end

  // Back end: sign fix-up and zero-divisor convention.
  ctl_t         ctl_l;
  dat_t         dat_l;
  logic [W-1:0] res_next;
  assign ctl_l = ctl_c[STAGES];
  assign dat_l = dat_c[STAGES];

  always_comb begin
    if (ctl_l.zero) begin
      res_next = ctl_l.want_rem ? ctl_l.orig_a : '1;
    end else if (ctl_l.want_rem) begin
      res_next = ctl_l.neg_r ? (~dat_l.rem + 1'b1) : dat_l.rem;
    end else begin
      res_next = ctl_l.neg_q ? (~dat_l.quo + 1'b1) : dat_l.quo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= ctl_l.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result      <= res_next;
      div_by_zero <= ctl_l.zero;
    end
  end

endmodule

// File: rtl/i64dm_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i64dm_cell
// One restoring-division step: shift in a dividend bit, trial subtract.
// ----------------------------------------------------------------------------
module i64dm_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  i64dm_pkg::ctl_t ctl_in,
  input  i64dm_pkg::dat_t dat_in,
  output i64dm_pkg::ctl_t ctl_out,
  output i64dm_pkg::dat_t dat_out
);
  import i64dm_pkg::*;

  logic [W:0]   trial;
  logic [W:0]   shifted;
  dat_t         dat_next;

  always_comb begin
    shifted = {dat_in.rem, dat_in.quo[W-1]};
    trial   = shifted - {1'b0, dat_in.dvs};
    dat_next.dvs = dat_in.dvs;
    if (!trial[W]) begin
      dat_next.rem = trial[W-1:0];
      dat_next.quo = {dat_in.quo[W-2:0], 1'b1};
    end else begin
      dat_next.rem = shifted[W-1:0];
      dat_next.quo = {dat_in.quo[W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else if (en) begin
      ctl_out.valid <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_out.want_rem <= ctl_in.want_rem;
      ctl_out.neg_q    <= ctl_in.neg_q;
      ctl_out.neg_r    <= ctl_in.neg_r;
      ctl_out.zero     <= ctl_in.zero;
      ctl_out.orig_a   <= ctl_in.orig_a;
      dat_out          <= dat_next;
    end
  end

endmodule
